// File: design/dmm_pkg.sv
// ----------------------------------------------------------------------------
// dmm_pkg: shared types and constants for the dense matrix multiplier
// Sizes, register and state codes, payload structs and the cell control group.
// ----------------------------------------------------------------------------
package dmm_pkg;

	localparam int MAX_DIM      = 8;
	localparam int ELEMENT_BITS = 16;
	localparam int DIM_W        = $clog2(MAX_DIM);
	localparam int EFF_W        = DIM_W + 1;
	localparam int ADDR_W       = $clog2(MAX_DIM * MAX_DIM);
	localparam int CNT_W        = $clog2(MAX_DIM * MAX_DIM + 1);
	localparam int PROD_W       = 2 * ELEMENT_BITS;
	localparam int SUM_W        = 35;
	localparam int CFG_W        = 4;
	localparam int PADDR_W      = 4;
	localparam int PDATA_W      = 32;

	// Register indexes
	typedef enum logic [1:0] {
		REG_ROWS  = 2'd0,
		REG_INNER = 2'd1,
		REG_COLS  = 2'd2
	} reg_idx_t;

	// Input function codes
	localparam logic FUNC_A = 1'b0;
	localparam logic FUNC_B = 1'b1;

	typedef enum logic [1:0] {
		ST_LOAD,
		ST_MAC,
		ST_WAIT,
		ST_DRAIN
	} state_t;

	typedef struct packed {
		logic                           func;
		logic signed [ELEMENT_BITS-1:0] element_value;
	} in_t;

	typedef struct packed {
		logic signed [SUM_W-1:0] product_value;
		logic [DIM_W-1:0]        result_row;
		logic [DIM_W-1:0]        result_col;
		logic                    last_result;
	} out_t;

	// Broadcast control from the sequencer to every cell
	typedef struct packed {
		logic signed [ELEMENT_BITS-1:0] a_val;
		logic [DIM_W-1:0]               j_s1;
		logic                           v_s1;
		logic                           v_s2;
		logic                           clr;
		logic                           capture;
		logic                           shift;
	} cell_ctl_t;

	// Clamp a configured dimension to 1..MAX_DIM
	function automatic logic [EFF_W-1:0] eff_dim(input logic [CFG_W-1:0] v);
		logic [EFF_W-1:0] r;
		if (v == '0) begin
			r = EFF_W'(1);
		end else if (v > CFG_W'(MAX_DIM)) begin
			r = EFF_W'(MAX_DIM);
		end else begin
			r = EFF_W'(v);
		end
		return r;
	endfunction

endpackage

// File: design/dmm_ram.sv
// ----------------------------------------------------------------------------
// dmm_ram: generic single-port RAM
// One write or one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module dmm_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write or read the addressed word
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

// File: design/dmm_cell.sv
// ----------------------------------------------------------------------------
// dmm_cell: one column cell of the multiply-accumulate chain
// Holds one column of B, accumulates one element of C and shifts results on.
// ----------------------------------------------------------------------------
module dmm_cell (
	input  logic                                   clk,
	input  dmm_pkg::cell_ctl_t                     ctl,
	input  logic                                   b_we,
	input  logic [dmm_pkg::DIM_W-1:0]              b_row,
	input  logic signed [dmm_pkg::ELEMENT_BITS-1:0] b_val,
	input  logic signed [dmm_pkg::SUM_W-1:0]       shift_in,
	output logic signed [dmm_pkg::SUM_W-1:0]       shift_out
);
	import dmm_pkg::*;

	logic signed [ELEMENT_BITS-1:0] b_q [MAX_DIM];
	logic signed [PROD_W-1:0]       p_s2;
	logic signed [SUM_W-1:0]        acc_q;
	logic signed [SUM_W-1:0]        shift_q;

	// Store the column of B
	always_ff @(posedge clk) begin
		if (b_we) begin
			b_q[b_row] <= b_val;
		end
	end

	// Multiply the broadcast A element by this column's B element
	always_ff @(posedge clk) begin
		if (ctl.v_s1) begin
			p_s2 <= PROD_W'(ctl.a_val) * PROD_W'(b_q[ctl.j_s1]);
		end
	end

	// Accumulate, wrapping to the sum width
	always_ff @(posedge clk) begin
		if (ctl.clr) begin
			acc_q <= '0;
		end else if (ctl.v_s2) begin
			acc_q <= acc_q + SUM_W'(p_s2);
		end
	end

	// Capture the finished sum, then hand it down the chain
	always_ff @(posedge clk) begin
		if (ctl.capture) begin
			shift_q <= acc_q;
		end else if (ctl.shift) begin
			shift_q <= shift_in;
		end
	end

	assign shift_out = shift_q;

endmodule

// File: design/dense_matrix_multiply_top.sv
// ----------------------------------------------------------------------------
// dense_matrix_multiply_top: C = A x B over a chain of column MAC cells
// Loads A into a RAM and B into the cells, then streams out C row-major.
// ----------------------------------------------------------------------------
// Usage:
//   req (valid/ready) carries one element: func selects A or B. Elements of
//   A and then B are sent row-major. req_ready is high only while loading.
//   The B element that completes B starts compute. Each row of C reads its
//   inner_dimension A elements from the RAM (one A element broadcast to all
//   cells per cycle), waits for the multiply and accumulate pipeline to
//   empty, then shifts the row out through cell 0 into the rsp register.
//   rsp (valid/ready) carries one C element; last_result marks the final one.
//   A stalled receiver holds the rsp register and freezes the shift chain.
//   The APB port writes rows_of_a, inner_dimension and cols_of_b at 0, 4
//   and 8; any write clears the load counters. Reset sets all three to 8,
//   clears the load counters and returns to loading. A and B storage is not cleared.
// ----------------------------------------------------------------------------
module dense_matrix_multiply_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          req_valid,
	output logic                          req_ready,
	input  dmm_pkg::in_t                  req,
	output logic                          rsp_valid,
	input  logic                          rsp_ready,
	output dmm_pkg::out_t                 rsp,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [dmm_pkg::PADDR_W-1:0]   paddr,
	input  logic [dmm_pkg::PDATA_W-1:0]   pwdata,
	output logic [dmm_pkg::PDATA_W-1:0]   prdata,
	output logic                          pready
);
	import dmm_pkg::*;

	logic [CFG_W-1:0]  rows_q, inner_q, cols_q;
	logic [EFF_W-1:0]  eff_m, eff_k, eff_n;
	logic [CNT_W-1:0]  mk_prod, kn_prod;
	state_t            state_q, state_d;
	logic [CNT_W-1:0]  a_cnt_q, a_cnt_d, b_cnt_q, b_cnt_d;
	logic [DIM_W-1:0]  b_row_q, b_row_d, b_col_q, b_col_d;
	logic [DIM_W-1:0]  r_q, r_d, j_q, j_d, col_q, col_d;
	logic [ADDR_W-1:0] a_ptr_q, a_ptr_d;
	logic              v_s1_q, v_s2_q;
	logic [DIM_W-1:0]  j_s1_q;
	logic              issue;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [ELEMENT_BITS-1:0] ram_rdata;
	logic              cfg_we;
	logic [1:0]        cfg_idx;
	logic              req_acc;
	logic              b_wr;
	logic              clr, capture, emit;
	cell_ctl_t         ctl;
	logic signed [SUM_W-1:0] chain [MAX_DIM+1];
	out_t              rsp_q;
	logic              rsp_valid_q;

	// Configuration port
	assign pready  = 1'b1;
	assign cfg_we  = psel && penable && pwrite;
	assign cfg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q  <= CFG_W'(MAX_DIM);
			inner_q <= CFG_W'(MAX_DIM);
			cols_q  <= CFG_W'(MAX_DIM);
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_ROWS:  rows_q  <= pwdata[CFG_W-1:0];
				REG_INNER: inner_q <= pwdata[CFG_W-1:0];
				REG_COLS:  cols_q  <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			REG_ROWS:  prdata = PDATA_W'(rows_q);
			REG_INNER: prdata = PDATA_W'(inner_q);
			REG_COLS:  prdata = PDATA_W'(cols_q);
			default:   prdata = '0;
		endcase
	end

	assign eff_m   = eff_dim(rows_q);
	assign eff_k   = eff_dim(inner_q);
	assign eff_n   = eff_dim(cols_q);
	assign mk_prod = CNT_W'(eff_m) * CNT_W'(eff_k);
	assign kn_prod = CNT_W'(eff_k) * CNT_W'(eff_n);

	assign req_ready = (state_q == ST_LOAD);
	assign req_acc   = req_valid && req_ready;
	assign emit      = (state_q == ST_DRAIN) && (!rsp_valid_q || rsp_ready);

	// Sequence loading, row compute and draining
	always_comb begin
		state_d  = state_q;
		a_cnt_d  = a_cnt_q;
		b_cnt_d  = b_cnt_q;
		b_row_d  = b_row_q;
		b_col_d  = b_col_q;
		r_d      = r_q;
		j_d      = j_q;
		col_d    = col_q;
		a_ptr_d  = a_ptr_q;
		issue    = 1'b0;
		ram_we   = 1'b0;
		ram_addr = a_ptr_q;
		b_wr     = 1'b0;
		clr      = 1'b0;
		capture  = 1'b0;
		case (state_q)
			ST_LOAD: begin
				if (req_acc && req.func == FUNC_A && a_cnt_q < mk_prod) begin
					ram_we   = 1'b1;
					ram_addr = a_cnt_q[ADDR_W-1:0];
					a_cnt_d  = a_cnt_q + CNT_W'(1);
				end
				if (req_acc && req.func == FUNC_B) begin
					b_wr    = 1'b1;
					b_cnt_d = b_cnt_q + CNT_W'(1);
					if (EFF_W'(b_col_q) + EFF_W'(1) == eff_n) begin
						b_col_d = '0;
						b_row_d = b_row_q + DIM_W'(1);
					end else begin
						b_col_d = b_col_q + DIM_W'(1);
					end
					if (b_cnt_q + CNT_W'(1) == kn_prod) begin
						state_d = ST_MAC;
						a_cnt_d = '0;
						b_cnt_d = '0;
						b_row_d = '0;
						b_col_d = '0;
						r_d     = '0;
						j_d     = '0;
						a_ptr_d = '0;
					end
				end
			end
			ST_MAC: begin
				issue   = 1'b1;
				clr     = (j_q == '0);
				a_ptr_d = a_ptr_q + ADDR_W'(1);
				if (EFF_W'(j_q) + EFF_W'(1) == eff_k) begin
					j_d     = '0;
					state_d = ST_WAIT;
				end else begin
					j_d = j_q + DIM_W'(1);
				end
			end
			ST_WAIT: begin
				if (!v_s1_q && !v_s2_q) begin
					capture = 1'b1;
					col_d   = '0;
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (emit) begin
					col_d = col_q + DIM_W'(1);
					if (EFF_W'(col_q) + EFF_W'(1) == eff_n) begin
						if (EFF_W'(r_q) + EFF_W'(1) == eff_m) begin
							state_d = ST_LOAD;
						end else begin
							r_d     = r_q + DIM_W'(1);
							state_d = ST_MAC;
						end
					end
				end
			end
			default: state_d = ST_LOAD;
		endcase
		// Drop partial loads on any register write
		if (cfg_we) begin
			a_cnt_d = '0;
			b_cnt_d = '0;
			b_row_d = '0;
			b_col_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			a_cnt_q <= '0;
			b_cnt_q <= '0;
			b_row_q <= '0;
			b_col_q <= '0;
			r_q     <= '0;
			j_q     <= '0;
			col_q   <= '0;
			a_ptr_q <= '0;
			v_s1_q  <= 1'b0;
			v_s2_q  <= 1'b0;
			j_s1_q  <= '0;
		end else begin
			state_q <= state_d;
			a_cnt_q <= a_cnt_d;
			b_cnt_q <= b_cnt_d;
			b_row_q <= b_row_d;
			b_col_q <= b_col_d;
			r_q     <= r_d;
			j_q     <= j_d;
			col_q   <= col_d;
			a_ptr_q <= a_ptr_d;
			v_s1_q  <= issue;
			v_s2_q  <= v_s1_q;
			j_s1_q  <= j_q;
		end
	end

	// A storage
	dmm_ram #(
		.WIDTH(ELEMENT_BITS),
		.DEPTH(MAX_DIM * MAX_DIM)
	) u_ram_a (
		.clk  (clk),
		.we   (ram_we),
		.addr (ram_addr),
		.wdata(req.element_value),
		.rdata(ram_rdata)
	);

	assign ctl.a_val   = ram_rdata;
	assign ctl.j_s1    = j_s1_q;
	assign ctl.v_s1    = v_s1_q;
	assign ctl.v_s2    = v_s2_q;
	assign ctl.clr     = clr;
	assign ctl.capture = capture;
	assign ctl.shift   = emit;

	// Cell chain, shifting toward cell 0
	assign chain[MAX_DIM] = '0;

	for (genvar c = 0; c < MAX_DIM; c++) begin : g_cell
		dmm_cell u_cell (
			.clk      (clk),
			.ctl      (ctl),
			.b_we     (b_wr && (b_col_q == DIM_W'(c))),
			.b_row    (b_row_q),
			.b_val    (req.element_value),
			.shift_in (chain[c+1]),
			.shift_out(chain[c])
		);
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			rsp_q.product_value <= chain[0];
			rsp_q.result_row    <= r_q;
			rsp_q.result_col    <= col_q;
			rsp_q.last_result   <= (EFF_W'(r_q) + EFF_W'(1) == eff_m) &&
			                       (EFF_W'(col_q) + EFF_W'(1) == eff_n);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_acc_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		v_s2_q |-> $past(v_s1_q))
		else $error("accumulate without a preceding multiply");

	a_a_bound: assert property (@(posedge clk) disable iff (!arst_n)
		a_cnt_q <= mk_prod)
		else $error("A load count beyond matrix size");

	a_b_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_LOAD) |-> (b_cnt_q < kn_prod))
		else $error("B load count reached size while loading");

	a_no_mac_drain: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DRAIN) |-> (!v_s1_q && !v_s2_q))
		else $error("drain started while products in flight");
`endif

endmodule
